>>> hdl/tds_pkg.sv
// shared types and constants for the timer divider search block
package tds_pkg;

  // width of the shared divider datapath and of its step counter
  localparam int DIV_W  = 32;
  localparam int STEP_W = 6;

  // result status codes
  typedef enum logic [1:0] {
    ST_EXACT      = 2'd0,
    ST_MISMATCH   = 2'd1,
    ST_INACCURATE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND_WAIT,
    S_SPLIT,
    S_SEARCH_WAIT,
    S_EVAL,
    S_FINAL,
    S_ACH_WAIT,
    S_DONE
  } state_t;

  // one request to the shared divider
  typedef struct packed {
    logic [DIV_W-1:0]  rem;    // starting partial remainder, below the divisor
    logic [DIV_W-1:0]  sh;     // dividend bits still to shift in, msb first
    logic [DIV_W-1:0]  dvs;    // divisor
    logic [STEP_W-1:0] steps;  // number of quotient bits to produce
  } div_req_t;

endpackage

>>> hdl/tds_div.sv
// shared restoring divider, one quotient bit per cycle
module tds_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  tds_pkg::div_req_t            req,
  output logic                         busy,
  output logic [tds_pkg::DIV_W-1:0]    rem,
  output logic [tds_pkg::DIV_W-1:0]    quo
);
  import tds_pkg::*;

  logic [STEP_W-1:0] count;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  sh;
  logic [DIV_W:0]    cat;
  logic [DIV_W+1:0]  diff;
  logic              ge;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    cat  = {rem, sh[DIV_W-1]};
    diff = {1'b0, cat} - {2'b00, dvs};
    ge   = !diff[DIV_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= req.steps;
    end else if (busy) begin
      count <= count - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= req.rem;
      sh  <= req.sh;
      dvs <= req.dvs;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : cat[DIV_W-1:0];
      sh  <= {sh[DIV_W-2:0], ge};
    end
  end

  assign busy = (count != '0);
  assign quo  = sh;

endmodule

>>> hdl/timer_divider_search.sv
// top level of the timer prescaler and reload search
//
// Each input word is a wanted update frequency; the block answers with one
// output word holding a status, a prescaler value, a reload value and the
// frequency those two really give with the configured timer clock. The
// divisor is clock_freq / target_freq rounded to nearest. A divisor of zero
// (zero target, or target above twice the clock) gives mismatch with all
// other fields zero. A divisor that fits the counter gives prescaler zero
// and reload divisor minus one. A larger divisor is split by trying ratios
// r upward from (divisor >> COUNTER_BITS) + 1 to the counter maximum,
// stopping at the first exact factor; with none, the first ratio of least
// remainder is taken and status is inaccurate. The smaller factor minus
// one is the prescaler. All arithmetic runs on one shared restoring
// divider that yields one quotient bit per clock. An item takes the
// rounding divide, then one divide per ratio tried, then (unless the
// divisor is zero or the ratio range is empty) the final divide for the
// achieved frequency, before its result moves to the output register.
// in_stall stays high from acceptance until the result moves to the output
// register, which holds it until taken while the next word is accepted.
// clock_freq is written over the cfg port, which is always ready and must
// only be written while the block is idle.
module timer_divider_search #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] target_freq,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] prescaler_value,
  output logic [15:0] reload_value,
  output logic [30:0] achieved_freq
);
  import tds_pkg::*;

  localparam int CB = COUNTER_BITS;
  // counter maximum, wide enough for any counter width
  localparam logic [63:0] LIMIT = (64'd1 << CB) - 64'd1;
  localparam logic [CB-1:0] LIMIT_CB = '1;

  state_t state, state_next;

  // configuration
  logic [30:0] clock_freq;

  // datapath registers
  logic          tgt_zero;   // target was zero
  logic [30:0]   d;          // rounded divisor
  logic [CB-1:0] r;          // ratio under test
  logic [CB-1:0] best_err;
  logic [CB-1:0] best_r;
  logic [CB-1:0] best_q;
  logic [CB-1:0] psc;
  logic [CB-1:0] arr;
  logic [30:0]   ach;
  status_t       st;

  // output register
  status_t       out_st;

  // shared divider
  logic             div_start;
  div_req_t         div_req;
  logic             div_busy;
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_quo;

  // decode helpers
  logic          in_take;
  logic          out_free;
  logic [31:0]   d_round;
  logic [63:0]   d_wide;
  logic [63:0]   r0_wide;
  logic          d_zero;
  logic          direct;
  logic          run;
  logic [CB-1:0] r_first;
  logic [CB-1:0] srch_r;
  logic [CB-1:0] err_n;
  logic [CB-1:0] q_n;
  logic          upd;
  logic          exact;
  logic          last;
  logic [30:0]   prod;

  tds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .busy  (div_busy),
    .rem   (div_rem),
    .quo   (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    // round to nearest: (q + 1) / 2
    d_round = (div_quo >> 1) + 32'(div_quo[0]);
    d_wide  = 64'(d);
    r0_wide = d_wide >> CB;
    d_zero  = (d == '0);
    direct  = (d_wide <= LIMIT);
    run     = (r0_wide < LIMIT);
    r_first = CB'(r0_wide + 64'd1);
    srch_r  = (state == S_SPLIT) ? r_first : r + CB'(1);
    // remainder is below r, quotient below 2^CB during the search
    err_n   = CB'(div_rem);
    q_n     = CB'(div_quo);
    upd     = (err_n < best_err);
    exact   = (err_n == '0);
    last    = (r == LIMIT_CB);
    // product of the chosen factors is the divisor less its remainder
    prod    = d - 31'(best_err);
  end

  // sequencer: next state and divider requests
  always_comb begin
    state_next    = state;
    div_start     = 1'b0;
    div_req.rem   = '0;
    div_req.sh    = 32'(clock_freq);
    div_req.dvs   = 32'(d);
    div_req.steps = STEP_W'(DIV_W);
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          // 2 * clock / target
          div_start   = 1'b1;
          div_req.sh  = {clock_freq, 1'b0};
          div_req.dvs = target_freq;
          state_next  = S_ROUND_WAIT;
        end
      end
      S_ROUND_WAIT: begin
        if (!div_busy) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (d_zero) begin
          state_next = S_DONE;
        end else if (direct) begin
          // achieved = clock / d
          div_start  = 1'b1;
          state_next = S_ACH_WAIT;
        end else if (run) begin
          div_start     = 1'b1;
          div_req.rem   = 32'(r0_wide);
          div_req.sh    = 32'(d_wide << (DIV_W - CB));
          div_req.dvs   = 32'(srch_r);
          div_req.steps = STEP_W'(CB);
          state_next    = S_SEARCH_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SEARCH_WAIT: begin
        if (!div_busy) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (exact || last) begin
          state_next = S_FINAL;
        end else begin
          // next ratio: d / (r + 1)
          div_start     = 1'b1;
          div_req.rem   = 32'(r0_wide);
          div_req.sh    = 32'(d_wide << (DIV_W - CB));
          div_req.dvs   = 32'(srch_r);
          div_req.steps = STEP_W'(CB);
          state_next    = S_SEARCH_WAIT;
        end
      end
      S_FINAL: begin
        // achieved = clock / (r * q)
        div_start   = 1'b1;
        div_req.dvs = 32'(prod);
        state_next  = S_ACH_WAIT;
      end
      S_ACH_WAIT: begin
        if (!div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_freq <= 31'd72000000;
    end else if (cfg_valid && cfg_ready) begin
      clock_freq <= cfg_data;
    end
  end

  // datapath registers follow the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          tgt_zero <= (target_freq == '0);
        end
      end
      S_ROUND_WAIT: begin
        if (!div_busy) begin
          d <= tgt_zero ? 31'd0 : d_round[30:0];
        end
      end
      S_SPLIT: begin
        psc      <= '0;
        ach      <= '0;
        r        <= r_first;
        best_err <= '1;
        if (d_zero) begin
          st  <= ST_MISMATCH;
          arr <= '0;
        end else if (direct) begin
          st  <= ST_EXACT;
          arr <= CB'(d_wide - 64'd1);
        end else begin
          // search start; these values stand only if the ratio range is empty, possible only with a narrow counter
          st  <= ST_INACCURATE;
          arr <= '1;
        end
      end
      S_SEARCH_WAIT: begin
      end
      S_EVAL: begin
        if (upd) begin
          best_err <= err_n;
          best_r   <= r;
          best_q   <= q_n;
        end
        if (!exact && !last) begin
          r <= r + CB'(1);
        end
        st <= exact ? ST_EXACT : ST_INACCURATE;
      end
      S_FINAL: begin
        if (best_r > best_q) begin
          psc <= best_q - CB'(1);
          arr <= best_r - CB'(1);
        end else begin
          psc <= best_r - CB'(1);
          arr <= best_q - CB'(1);
        end
      end
      S_ACH_WAIT: begin
        if (!div_busy) begin
          ach <= div_quo[30:0];
        end
      end
      S_DONE: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_st          <= st;
      prescaler_value <= 16'(psc);
      reload_value    <= 16'(arr);
      achieved_freq   <= ach;
    end
  end

  assign status = out_st;

  // the divider is never restarted mid-operation
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // a search remainder is always below the ratio that produced it
  a_err_below_r: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> div_rem < 32'(r))
    else $error("search remainder not below ratio");

  // mismatch words carry zero fields
  a_mismatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_st == ST_MISMATCH |->
      prescaler_value == '0 && reload_value == '0 && achieved_freq == '0)
    else $error("mismatch word with nonzero fields");

  // with the default counter, a usable divisor always reaches a nonzero frequency
  a_ach_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_st == ST_EXACT |-> achieved_freq != '0)
    else $error("exact word with zero achieved frequency");

endmodule

>>> dv/testbench.sv
// testbench for the timer prescaler and reload search block
`timescale 1ns / 1ps

module testbench;
  import tds_pkg::*;

  localparam int CNT_BITS = 16;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
  // random targets whose search would try this many ratios or more are redrawn
  localparam int SEARCH_CAP = 128;
  // cycles with no word moving anywhere before the run is given up; the worst
  // legal item searches about 65000 ratios
  localparam int STALL_LIMIT = 4000000;
  // quiet cycles after the last result
  localparam int TAIL_CYCLES = 100;
  localparam int WORDS_PER_PHASE = 26;

  typedef struct packed {
    status_t     status;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [30:0] achieved;
  } setting_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // one directed row: a clock write, or a target with an optional typed answer
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        typed;
    setting_t    want;
  } row_t;

  localparam setting_t NO_TYPED = '{ST_EXACT, 16'd0, 16'd0, 31'd0};
  localparam setting_t MISMATCH = '{ST_MISMATCH, 16'd0, 16'd0, 31'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = 31'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] target_freq = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] prescaler_value;
  logic [15:0] reload_value;
  logic [30:0] achieved_freq;

  // model copy of the clock register
  logic [30:0] clock_hz = 31'd72000000;
  setting_t    pending_settings [$];
  setting_t    oldest;
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_pct = 17;
  int          recv_pct = 50;

  // directed rows: the typed answers are the trivially readable ones
  row_t directed_rows [0:22] = '{
    // reset clock of 72 MHz
    '{ROW_ITEM, 32'd0,         1'b1, MISMATCH},      // zero target
    '{ROW_ITEM, 32'hFFFFFFFF,  1'b1, MISMATCH},      // all ones target
    '{ROW_ITEM, 32'd144000001, 1'b1, MISMATCH},      // just above twice the clock
    '{ROW_ITEM, 32'd144000000, 1'b1, '{ST_EXACT, 16'd0, 16'd0, 31'd72000000}},
    '{ROW_ITEM, 32'd72000000,  1'b1, '{ST_EXACT, 16'd0, 16'd0, 31'd72000000}},
    '{ROW_ITEM, 32'h80000000,  1'b1, MISMATCH},
    '{ROW_ITEM, 32'h55555555,  1'b1, MISMATCH},
    '{ROW_ITEM, 32'hAAAAAAAA,  1'b1, MISMATCH},
    '{ROW_ITEM, 32'd1,         1'b0, NO_TYPED},      // largest divisor, short search
    '{ROW_ITEM, 32'd2,         1'b0, NO_TYPED},
    '{ROW_ITEM, 32'd1000,      1'b0, NO_TYPED},      // split by two
    '{ROW_ITEM, 32'd1100,      1'b0, NO_TYPED},      // just fits the counter
    // slowest clock
    '{ROW_CFG,  32'd1,         1'b0, NO_TYPED},
    '{ROW_ITEM, 32'd0,         1'b1, MISMATCH},
    '{ROW_ITEM, 32'd1,         1'b1, '{ST_EXACT, 16'd0, 16'd0, 31'd1}},
    '{ROW_ITEM, 32'd2,         1'b1, '{ST_EXACT, 16'd0, 16'd0, 31'd1}},
    '{ROW_ITEM, 32'd3,         1'b1, MISMATCH},      // divisor rounds to zero
    // fastest clock, a prime, so target 1 has no exact factor
    '{ROW_CFG,  32'h7FFFFFFF,  1'b0, NO_TYPED},
    '{ROW_ITEM, 32'hFFFFFFFF,  1'b1, MISMATCH},
    '{ROW_ITEM, 32'hFFFFFFFE,  1'b1, '{ST_EXACT, 16'd0, 16'd0, 31'h7FFFFFFF}},
    '{ROW_ITEM, 32'd32768,     1'b0, NO_TYPED},      // divisor one past the counter
    '{ROW_ITEM, 32'd32769,     1'b0, NO_TYPED},
    '{ROW_ITEM, 32'd1,         1'b0, NO_TYPED}       // inaccurate, full search
  };

  timer_divider_search #(.COUNTER_BITS(CNT_BITS)) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .target_freq     (target_freq),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .prescaler_value (prescaler_value),
    .reload_value    (reload_value),
    .achieved_freq   (achieved_freq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // divisor clock / target rounded to nearest, zero for a zero target
  function automatic longint unsigned rounded_divisor(input logic [30:0] hz,
                                                      input logic [31:0] tgt);
    longint unsigned c;
    longint unsigned t;
    c = hz;
    t = tgt;
    if (t == 0) return 0;
    return ((2 * c) / t + 1) / 2;
  endfunction

  // prescaler, reload and achieved frequency the block should report
  function automatic setting_t compute_timer_setting(input logic [30:0] hz,
                                                     input logic [31:0] tgt);
    longint unsigned d, r, q, err, best_err, best_r, psc, arr, c;
    setting_t res;
    res = '{ST_EXACT, 16'd0, 16'd0, 31'd0};
    c = hz;
    d = rounded_divisor(hz, tgt);
    if (d == 0) begin
      res.status = ST_MISMATCH;
      return res;
    end
    if (d <= CNT_MAX) begin
      psc = 0;
      arr = d - 1;
    end else begin
      // walk ratios up from the smallest one that keeps the quotient in range
      r = d >> CNT_BITS;
      best_err = '1;
      best_r = 0;
      q = 0;
      err = 1;
      while (r < CNT_MAX) begin
        r++;
        q = d / r;
        err = d - q * r;
        if (err < best_err) begin
          best_err = err;
          best_r = r;
        end
        if (err == 0) break;
      end
      if (err != 0) begin
        // no exact factor: fall back to the first ratio of least remainder
        r = best_r;
        q = (r != 0) ? d / r : 0;
        res.status = ST_INACCURATE;
      end
      // smaller factor goes to the prescaler
      if (r > q) begin
        psc = (q != 0) ? q - 1 : 0;
        arr = r - 1;
      end else begin
        psc = (r != 0) ? r - 1 : 0;
        arr = q - 1;
      end
    end
    res.prescaler = psc[15:0];
    res.reload = arr[15:0];
    res.achieved = 31'(c / ((psc + 1) * (arr + 1)));
    return res;
  endfunction

  // ratios the search tries for this target, clipped at the cap; a search
  // that runs out without an exact factor counts as the cap
  function automatic int ratios_to_try(input logic [30:0] hz, input logic [31:0] tgt);
    longint unsigned d, r;
    int n;
    d = rounded_divisor(hz, tgt);
    if (d <= CNT_MAX) return 0;
    r = d >> CNT_BITS;
    n = 0;
    while (r < CNT_MAX) begin
      r++;
      n++;
      if (d % r == 0 || n >= SEARCH_CAP) return n;
    end
    return SEARCH_CAP;
  endfunction

  // mostly targets the counter holds or that split quickly, some noise
  function automatic logic [31:0] draw_target(input logic [30:0] hz);
    logic [31:0] two_c;
    logic [31:0] t;
    int kind;
    two_c = {hz, 1'b0};
    for (int tries = 0; tries < 40; tries++) begin
      kind = $urandom_range(99);
      if (kind < 12) t = $urandom();
      else if (kind < 14) t = 32'd0;
      else if (kind < 18) t = $urandom_range(32'hFFFFFFFF, two_c + 32'd1);
      else if (kind < 58) t = $urandom_range(two_c, 32'(hz / 32768) + 32'd1);
      else t = $urandom_range(32'(hz >> CNT_BITS) + 32'd1, 32'd1);
      if (ratios_to_try(hz, t) < SEARCH_CAP) return t;
    end
    return two_c;
  endfunction

  // hold off until the block has handed back every word it took; the last
  // word sent is withdrawn so the block cannot take it a second time
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  // clock register write, only issued once the block is idle
  task automatic write_clock(input logic [30:0] hz);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    clock_hz = hz;
  endtask

  // present one target word, with random idle cycles ahead of it
  task automatic send_word(input logic [31:0] t, input setting_t want);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target_freq <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_settings.push_back(want);
  endtask

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_pct);

  // result checker: each word taken is compared to the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_settings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, status %0d prescaler %0d reload %0d",
                 $time, status, prescaler_value, reload_value);
      end else begin
        oldest = pending_settings.pop_front();
        if (status !== oldest.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, oldest.status, status);
        end
        if (prescaler_value !== oldest.prescaler) begin
          errors++;
          $display("%0t: prescaler expected %0d got %0d",
                   $time, oldest.prescaler, prescaler_value);
        end
        if (reload_value !== oldest.reload) begin
          errors++;
          $display("%0t: reload expected %0d got %0d", $time, oldest.reload, reload_value);
        end
        if (achieved_freq !== oldest.achieved) begin
          errors++;
          $display("%0t: achieved freq expected %0d got %0d",
                   $time, oldest.achieved, achieved_freq);
        end
      end
    end
  end

  // watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_settings.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table, first idling mode
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_clock(directed_rows[i].value[30:0]);
      end else if (directed_rows[i].typed) begin
        send_word(directed_rows[i].value, directed_rows[i].want);
      end else begin
        send_word(directed_rows[i].value,
                  compute_timer_setting(clock_hz, directed_rows[i].value));
      end
    end

    // random phases: sender light / receiver heavy, swapped, then no idling
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_pct = 17;
          recv_pct = 50;
          write_clock(31'd72000000);
        end
        1: begin
          send_pct = 50;
          recv_pct = 17;
          write_clock(31'($urandom_range(32'h7FFFFFFF, 32'd1)));
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
          write_clock(31'($urandom_range(32'd200000000, 32'd1000)));
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // now and then let the pipe drain completely
        if ($urandom_range(24) == 0) wait_drained();
        t = draw_target(clock_hz);
        send_word(t, compute_timer_setting(clock_hz, t));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_settings.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_settings.size());
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
